/* rtl/ook_pulse_frame_recognizer_defines.svh */
// Assertion macros shared by the OOK pulse frame recognizer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef OOK_PULSE_FRAME_RECOGNIZER_DEFINES_SVH
`define OOK_PULSE_FRAME_RECOGNIZER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OOKPF_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("ookpf assertion failed");

// next-cycle implication, disabled during reset
`define OOKPF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("ookpf assertion failed");

`endif

/* rtl/ookpf_pkg.sv */
// Package for the OOK pulse frame recognizer: payload and config types,
// register indexes, reset values and the pulse window / quality functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ookpf_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int WIN_W      = 15;
  localparam int LEN_W      = 16;
  localparam int CNT_W      = 8;

  typedef enum logic [2:0] {
    REG_MLMIN  = 3'd0,
    REG_MLMAX  = 3'd1,
    REG_MHMIN  = 3'd2,
    REG_MHMAX  = 3'd3,
    REG_SLMIN  = 3'd4,
    REG_SLMAX  = 3'd5,
    REG_RHMIN  = 3'd6,
    REG_MINLEN = 3'd7
  } reg_idx_t;

  localparam logic [WIN_W-1:0] RST_MLMIN  = 15'd1250;
  localparam logic [WIN_W-1:0] RST_MLMAX  = 15'd2100;
  localparam logic [WIN_W-1:0] RST_MHMIN  = 15'd280;
  localparam logic [WIN_W-1:0] RST_MHMAX  = 15'd950;
  localparam logic [WIN_W-1:0] RST_SLMIN  = 15'd5000;
  localparam logic [WIN_W-1:0] RST_SLMAX  = 15'd6300;
  localparam logic [WIN_W-1:0] RST_RHMIN  = 15'd450;
  localparam logic [LEN_W-1:0] RST_MINLEN = 16'd18;

  localparam logic [6:0] QUAL_BASE   = 7'd82;
  localparam logic [6:0] QUAL_LEADER = 7'd6;
  localparam logic [6:0] QUAL_MAX    = 7'd100;
  localparam logic [2:0] MARKER_CAP  = 3'd6;

  typedef struct packed {
    logic signed [15:0] pulse_width;
    logic               last_pulse;
  } in_t;

  typedef struct packed {
    logic             matched;
    logic [6:0]       quality;
    logic [CNT_W-1:0] repeats;
    logic [LEN_W-1:0] capture_length;
  } out_t;

  typedef struct packed {
    logic [WIN_W-1:0] marker_low_min;
    logic [WIN_W-1:0] marker_low_max;
    logic [WIN_W-1:0] marker_high_min;
    logic [WIN_W-1:0] marker_high_max;
    logic [WIN_W-1:0] sync_low_min;
    logic [WIN_W-1:0] sync_low_max;
    logic [WIN_W-1:0] recovery_high_min;
    logic [LEN_W-1:0] min_capture_length;
  } cfg_t;

  // high level: strictly positive width
  function automatic logic is_high(input logic signed [15:0] p);
    return !p[15] && (p != 16'sd0);
  endfunction

  // magnitude of a pulse of the requested level inside [lo, hi]
  function automatic logic in_window(input logic signed [15:0] p, input logic high,
                                     input logic [WIN_W-1:0] lo,
                                     input logic [WIN_W-1:0] hi);
    logic [16:0] ext;
    logic [16:0] mag;
    logic        lvl_ok;
    ext    = {p[15], p};
    mag    = high ? ext : (17'd0 - ext);
    lvl_ok = high ? is_high(p) : p[15];
    return lvl_ok && (mag >= {2'b00, lo}) && (mag <= {2'b00, hi});
  endfunction

  function automatic logic [6:0] quality_of(input logic [CNT_W-1:0] markers,
                                            input logic leader);
    logic [2:0] m;
    logic [6:0] q;
    m = (markers > {5'd0, MARKER_CAP}) ? MARKER_CAP : markers[2:0];
    q = QUAL_BASE + {3'b000, m, 1'b0} + (leader ? QUAL_LEADER : 7'd0);
    return (q > QUAL_MAX) ? QUAL_MAX : q;
  endfunction

endpackage

`default_nettype wire

/* rtl/ookpf_cfg.sv */
// Configuration register bank of the OOK pulse frame recognizer (APB style).
// Depends on ookpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ookpf_cfg
  import ookpf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MLMIN:  cfg_nxt.marker_low_min     = pwdata[WIN_W-1:0];
        REG_MLMAX:  cfg_nxt.marker_low_max     = pwdata[WIN_W-1:0];
        REG_MHMIN:  cfg_nxt.marker_high_min    = pwdata[WIN_W-1:0];
        REG_MHMAX:  cfg_nxt.marker_high_max    = pwdata[WIN_W-1:0];
        REG_SLMIN:  cfg_nxt.sync_low_min       = pwdata[WIN_W-1:0];
        REG_SLMAX:  cfg_nxt.sync_low_max       = pwdata[WIN_W-1:0];
        REG_RHMIN:  cfg_nxt.recovery_high_min  = pwdata[WIN_W-1:0];
        REG_MINLEN: cfg_nxt.min_capture_length = pwdata[LEN_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MLMIN:  prdata = {17'd0, cfg_r.marker_low_min};
      REG_MLMAX:  prdata = {17'd0, cfg_r.marker_low_max};
      REG_MHMIN:  prdata = {17'd0, cfg_r.marker_high_min};
      REG_MHMAX:  prdata = {17'd0, cfg_r.marker_high_max};
      REG_SLMIN:  prdata = {17'd0, cfg_r.sync_low_min};
      REG_SLMAX:  prdata = {17'd0, cfg_r.sync_low_max};
      REG_RHMIN:  prdata = {17'd0, cfg_r.recovery_high_min};
      REG_MINLEN: prdata = {16'd0, cfg_r.min_capture_length};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.marker_low_min     <= RST_MLMIN;
      cfg_r.marker_low_max     <= RST_MLMAX;
      cfg_r.marker_high_min    <= RST_MHMIN;
      cfg_r.marker_high_max    <= RST_MHMAX;
      cfg_r.sync_low_min       <= RST_SLMIN;
      cfg_r.sync_low_max       <= RST_SLMAX;
      cfg_r.recovery_high_min  <= RST_RHMIN;
      cfg_r.min_capture_length <= RST_MINLEN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/ookpf_core.sv */
// Recognizer datapath: input register, pulse history and capture counters,
// match evaluation and result register. Depends on ookpf_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "ook_pulse_frame_recognizer_defines.svh"

module ookpf_core
  import ookpf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  // input stage
  logic s1_valid_r, s1_valid_nxt;
  in_t  s1_item_r;
  logic accept;
  logic advance;

  // capture state
  logic signed [15:0] hist_r [3];
  logic [LEN_W-1:0]   pcnt_r, pcnt_upd;
  logic [CNT_W-1:0]   mcnt_r, mcnt_upd;
  logic [CNT_W-1:0]   scnt_r, scnt_upd;
  logic               alt_r, alt_upd;
  logic               lead_r, lead_upd;

  // result stage
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;
  out_t result;

  logic signed [15:0] cur;
  logic               match;
  logic               mark_pair, sync_low, leader_hit;

  assign advance  = s1_valid_r && (!s1_item_r.last_pulse || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign cur      = s1_item_r.pulse_width;

  always_comb begin
    mark_pair  = in_window(hist_r[0], 1'b0, cfg.marker_low_min, cfg.marker_low_max) &&
                 in_window(cur, 1'b1, cfg.marker_high_min, cfg.marker_high_max);
    sync_low   = in_window(cur, 1'b0, cfg.sync_low_min, cfg.sync_low_max);
    leader_hit = in_window(hist_r[2], 1'b0, cfg.marker_low_min, cfg.marker_low_max) &&
                 in_window(hist_r[1], 1'b1, cfg.marker_high_min, cfg.marker_high_max) &&
                 in_window(hist_r[0], 1'b0, cfg.sync_low_min, cfg.sync_low_max) &&
                 in_window(cur, 1'b1, cfg.recovery_high_min, cfg.marker_high_max);

    alt_upd  = alt_r && !((pcnt_r != '0) && (is_high(hist_r[0]) == is_high(cur)));
    mcnt_upd = (mark_pair && (mcnt_r != '1)) ? mcnt_r + 1'b1 : mcnt_r;
    scnt_upd = (sync_low && (scnt_r != '1)) ? scnt_r + 1'b1 : scnt_r;
    lead_upd = lead_r || leader_hit;
    pcnt_upd = (pcnt_r != '1) ? pcnt_r + 1'b1 : pcnt_r;

    match = (pcnt_upd >= cfg.min_capture_length) && alt_upd &&
            (lead_upd || (mcnt_upd >= 8'd3) || ((mcnt_upd >= 8'd2) && (scnt_upd != '0)));

    result = '0;
    if (match) begin
      result.matched        = 1'b1;
      result.quality        = quality_of(mcnt_upd, lead_upd);
      result.repeats        = (mcnt_upd != '0) ? mcnt_upd : 8'd1;
      result.capture_length = pcnt_upd;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance && s1_item_r.last_pulse) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_r[0]   <= '0;
      hist_r[1]   <= '0;
      hist_r[2]   <= '0;
      pcnt_r      <= '0;
      mcnt_r      <= '0;
      scnt_r      <= '0;
      alt_r       <= 1'b1;
      lead_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        if (s1_item_r.last_pulse) begin
          hist_r[0] <= '0;
          hist_r[1] <= '0;
          hist_r[2] <= '0;
          pcnt_r    <= '0;
          mcnt_r    <= '0;
          scnt_r    <= '0;
          alt_r     <= 1'b1;
          lead_r    <= 1'b0;
        end else begin
          hist_r[0] <= cur;
          hist_r[1] <= hist_r[0];
          hist_r[2] <= hist_r[1];
          pcnt_r    <= pcnt_upd;
          mcnt_r    <= mcnt_upd;
          scnt_r    <= scnt_upd;
          alt_r     <= alt_upd;
          lead_r    <= lead_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (advance && s1_item_r.last_pulse) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `OOKPF_ASSERT_IMPL(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r && out_valid_r)
  `OOKPF_ASSERT_NEXT(a_clear_after_last, clk, rst_n, advance && s1_item_r.last_pulse,
                     (pcnt_r == '0) && alt_r && !lead_r && out_valid_r)
  `OOKPF_ASSERT_IMPL(a_nomatch_zero, clk, rst_n, out_valid_r && !out_data_r.matched,
                     (out_data_r.quality == '0) && (out_data_r.repeats == '0) &&
                     (out_data_r.capture_length == '0))
  `OOKPF_ASSERT_IMPL(a_match_range, clk, rst_n, out_valid_r && out_data_r.matched,
                     (out_data_r.quality >= QUAL_BASE) && (out_data_r.quality <= QUAL_MAX) &&
                     (out_data_r.repeats != '0) && (out_data_r.capture_length != '0))

endmodule

`default_nettype wire

/* rtl/ook_pulse_frame_recognizer.sv */
// OOK pulse frame recognizer top level: one pulse per cycle, back to back.
// A final pulse is held in the input register, then its result is registered on out_data.
// Throughput: one pulse per cycle; set by the single-pass window compare and counter update.
// Input stalls only while a final pulse waits for a stalled result register.
// Reset (rst_n, synchronous): registers return to defaults, capture state cleared.
// Depends on ookpf_pkg, ookpf_cfg and ookpf_core.
`timescale 1ns / 1ps
`default_nettype none

module ook_pulse_frame_recognizer
  import ookpf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t cfg;

  ookpf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ookpf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
